// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the trail segment pool RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSAF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tsaf assertion failed");
`define TSAF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tsaf assertion failed");
`else
`define TSAF_ASSERT(label, clk, rst, prop)
`define TSAF_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ===== rtl/tsaf_pkg.sv =====
// Shared types and constants of the trail segment aging pool.
package tsaf_pkg;
   localparam int SlotsDefault = 32;
   localparam int TimeW        = 24;
   localparam int TimerW       = 25;
   localparam int CoordW       = 32;
   localparam int OneSecond    = 65536;
   localparam logic [TimerW-1:0] TimerMax     = {TimerW{1'b1}};
   localparam logic [TimeW-1:0]  FadeResetVal = TimeW'(OneSecond);

   // One segment as held in a cell of the chain.
   typedef struct packed {
      logic             used;
      logic [TimeW-1:0] rem;
   } rec_type;

   // The point pair carried by one tick.
   typedef struct packed {
      logic [CoordW-1:0] first_x;
      logic [CoordW-1:0] first_y;
      logic [CoordW-1:0] first_z;
      logic [CoordW-1:0] second_x;
      logic [CoordW-1:0] second_y;
      logic [CoordW-1:0] second_z;
   } pts_type;
endpackage

// ===== rtl/tsaf_cell.sv =====
// One segment cell of the rotating chain.
module tsaf_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  tsaf_pkg::rec_type rec_in,
   input  logic             load_en,
   input  tsaf_pkg::rec_type load_rec,
   output tsaf_pkg::rec_type rec_out
);
   import tsaf_pkg::*;

   rec_type seg_ff;
   rec_type seg_in;

   // Shifting and loading never overlap; the load wins should they ever do.
   always_comb begin
      seg_in = seg_ff;
      if (load_en) begin
         seg_in = load_rec;
      end else if (shift_en) begin
         seg_in = rec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff <= '0;
      end else begin
         seg_ff <= seg_in;
      end
   end

   assign rec_out = seg_ff;
endmodule

// ===== rtl/trail_segment_aging_fifo.sv =====
// Top level of the trail segment aging pool: control, sweep datapath and point store.
// Usage: one tick beat is issued on start with the req_ fields while busy is low.
// The block ages every live segment by req_step_time, frees those whose time runs
// out, and, when a point pair is offered and the emit timer is due, stores the pair
// in the lowest free slot with the fade lifetime taken from the fade_time register.
// Steps of a tick: the beat is accepted, the sweep rotates the segment ring once
// through the ageing unit at its end, and the finish state settles the emission;
// the result beat appears on the rsp_ ports for one cycle, marked by rsp_valid,
// as busy drops. A single ageing unit serves every slot, visited once per slot,
// and start is ignored while busy, so a new tick waits for the last result.
// The receiver cannot stall the result; it must take the beat in that cycle.
// The configuration register sits on the APB-style port at byte address 0; the user
// is to write it only while the block is idle, which the block does not enforce.
// Reads return its value at once. Reset clears every segment, the emit timer and
// the result strobe, and loads fade_time with one second; the point store needs no
// clearing, since its words are only written, never read back into a result.
`include "assert_macros.svh"

module trail_segment_aging_fifo #(
   parameter int SLOTS = tsaf_pkg::SlotsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   // tick channel
   input  logic                        start,
   output logic                        busy,
   input  logic [tsaf_pkg::TimeW-1:0]  req_step_time,
   input  logic                        req_have_points,
   input  logic                        req_closing,
   input  logic [tsaf_pkg::CoordW-1:0] req_first_x,
   input  logic [tsaf_pkg::CoordW-1:0] req_first_y,
   input  logic [tsaf_pkg::CoordW-1:0] req_first_z,
   input  logic [tsaf_pkg::CoordW-1:0] req_second_x,
   input  logic [tsaf_pkg::CoordW-1:0] req_second_y,
   input  logic [tsaf_pkg::CoordW-1:0] req_second_z,
   // result channel
   output logic                        rsp_valid,
   output logic [5:0]                  rsp_live_segments,
   output logic                        rsp_stored,
   output logic [4:0]                  rsp_stored_slot,
   output logic                        rsp_dropped_full,
   output logic [5:0]                  rsp_expired_count,
   output logic                        rsp_finished,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tsaf_pkg::*;

   localparam int SlotW         = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CntW          = $clog2(SLOTS + 1);
   localparam int EmitThreshold = (OneSecond + SLOTS - 1) / SLOTS;
   localparam logic [SlotW-1:0] LastSlot = SlotW'(SLOTS - 1);

   localparam logic [1:0] StIdle   = 2'd0;
   localparam logic [1:0] StSweep  = 2'd1;
   localparam logic [1:0] StFinish = 2'd2;

   // ------------------------------------------------------------------
   // Configuration register. Only register 0 exists; the word select bit
   // paddr[2] tells it apart from the empty space above it.
   // ------------------------------------------------------------------
   logic [TimeW-1:0] fade_ff, fade_in;
   logic             cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
   assign fade_in = cfg_wr ? pwdata[TimeW-1:0] : fade_ff;
   assign prdata = paddr[2] ? 32'd0 : 32'(fade_ff);

   // ------------------------------------------------------------------
   // Control and per-tick registers.
   // ------------------------------------------------------------------
   logic [1:0]        state_ff, state_in;
   logic [TimerW-1:0] timer_ff, timer_in;
   logic [TimeW-1:0]  dt_ff, dt_in;
   logic              due_ff, due_in;
   logic              closing_ff, closing_in;
   pts_type           pts_ff, pts_in;
   logic [SlotW-1:0]  idx_ff, idx_in;
   logic [CntW-1:0]   expired_ff, expired_in;
   logic [CntW-1:0]   live_ff, live_in;
   logic              found_ff, found_in;
   logic [SlotW-1:0]  free_ff, free_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [5:0]        rsp_live_ff, rsp_live_in;
   logic              rsp_stored_ff, rsp_stored_in;
   logic [4:0]        rsp_slot_ff, rsp_slot_in;
   logic              rsp_drop_ff, rsp_drop_in;
   logic [5:0]        rsp_exp_ff, rsp_exp_in;
   logic              rsp_fin_ff, rsp_fin_in;

   logic              accept;
   logic [TimerW:0]   timer_sum;
   logic [TimerW-1:0] timer_sat;
   logic              emit_now;
   logic              drop_now;
   logic [CntW-1:0]   live_final;

   assign busy   = (state_ff != StIdle);
   assign accept = start & ~busy;

   // The emit timer saturates rather than wrapping; emission is due once the
   // timer times SLOTS reaches one second, i.e. at the rounded-up quotient.
   assign timer_sum = {1'b0, timer_ff} + (TimerW + 1)'(req_step_time);
   assign timer_sat = timer_sum[TimerW] ? TimerMax : timer_sum[TimerW-1:0];

   // ------------------------------------------------------------------
   // The segment ring. Each cell hands its record on every sweep cycle; the
   // record leaving the last cell passes through the ageing unit on its way
   // back into cell 0, so after SLOTS shifts every record is home again.
   // ------------------------------------------------------------------
   rec_type chain_out [SLOTS];
   rec_type age_rec;
   rec_type new_rec;
   logic    age_expire;
   logic    shift_en;

   assign shift_en = (state_ff == StSweep);
   assign new_rec  = '{used: 1'b1, rem: fade_ff};

   always_comb begin
      age_rec    = chain_out[SLOTS-1];
      age_expire = 1'b0;
      if (chain_out[SLOTS-1].used) begin
         if (dt_ff > chain_out[SLOTS-1].rem) begin
            // A segment equal to the step survives with nothing left.
            age_rec.used = 1'b0;
            age_rec.rem  = '0;
            age_expire   = 1'b1;
         end else begin
            age_rec.rem = chain_out[SLOTS-1].rem - dt_ff;
         end
      end
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      rec_type cell_in;
      logic    load_en;

      if (i == 0) begin : g_head
         assign cell_in = age_rec;
      end else begin : g_link
         assign cell_in = chain_out[i-1];
      end

      assign load_en = (state_ff == StFinish) & emit_now & (free_ff == SlotW'(i));

      tsaf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .rec_in   (cell_in),
         .load_en  (load_en),
         .load_rec (new_rec),
         .rec_out  (chain_out[i])
      );
   end

   // ------------------------------------------------------------------
   // Sequencer. The sweep visits slots from the highest down, so the last
   // free slot seen is the lowest one.
   // ------------------------------------------------------------------
   assign emit_now   = due_ff & found_ff;
   assign drop_now   = due_ff & ~found_ff;
   assign live_final = live_ff + CntW'(emit_now);

   always_comb begin
      state_in     = state_ff;
      timer_in     = timer_ff;
      dt_in        = dt_ff;
      due_in       = due_ff;
      closing_in   = closing_ff;
      pts_in       = pts_ff;
      idx_in       = idx_ff;
      expired_in   = expired_ff;
      live_in      = live_ff;
      found_in     = found_ff;
      free_in      = free_ff;
      rsp_valid_in = 1'b0;
      rsp_live_in  = rsp_live_ff;
      rsp_stored_in = rsp_stored_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_drop_in  = rsp_drop_ff;
      rsp_exp_in   = rsp_exp_ff;
      rsp_fin_in   = rsp_fin_ff;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               due_in     = req_have_points & (timer_sat >= TimerW'(EmitThreshold));
               timer_in   = due_in ? '0 : timer_sat;
               dt_in      = req_step_time;
               closing_in = req_closing;
               pts_in     = '{first_x: req_first_x, first_y: req_first_y,
                              first_z: req_first_z, second_x: req_second_x,
                              second_y: req_second_y, second_z: req_second_z};
               idx_in     = LastSlot;
               expired_in = '0;
               live_in    = '0;
               found_in   = 1'b0;
               free_in    = '0;
               state_in   = StSweep;
            end
         end
         StSweep: begin
            expired_in = expired_ff + CntW'(age_expire);
            live_in    = live_ff + CntW'(age_rec.used);
            if (!age_rec.used) begin
               found_in = 1'b1;
               free_in  = idx_ff;
            end
            idx_in = idx_ff - SlotW'(1);
            if (idx_ff == '0) begin
               state_in = StFinish;
            end
         end
         StFinish: begin
            rsp_valid_in  = 1'b1;
            rsp_live_in   = 6'(live_final);
            rsp_stored_in = emit_now;
            rsp_slot_in   = emit_now ? 5'(free_ff) : 5'd0;
            rsp_drop_in   = drop_now;
            rsp_exp_in    = 6'(expired_ff);
            rsp_fin_in    = ~drop_now & closing_ff & (live_final == '0);
            state_in      = StIdle;
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         timer_ff     <= '0;
         fade_ff      <= FadeResetVal;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timer_ff     <= timer_in;
         fade_ff      <= fade_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff         <= dt_in;
      due_ff        <= due_in;
      closing_ff    <= closing_in;
      pts_ff        <= pts_in;
      idx_ff        <= idx_in;
      expired_ff    <= expired_in;
      live_ff       <= live_in;
      found_ff      <= found_in;
      free_ff       <= free_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_stored_ff <= rsp_stored_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_drop_ff   <= rsp_drop_in;
      rsp_exp_ff    <= rsp_exp_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   // ------------------------------------------------------------------
   // Point store: one row of six words per slot, written when a pair lands.
   // ------------------------------------------------------------------
   pts_type point_mem [SLOTS];

   always_ff @(posedge clock) begin
      if ((state_ff == StFinish) && emit_now) begin
         point_mem[free_ff] <= pts_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_live_segments = rsp_live_ff;
   assign rsp_stored        = rsp_stored_ff;
   assign rsp_stored_slot   = rsp_slot_ff;
   assign rsp_dropped_full  = rsp_drop_ff;
   assign rsp_expired_count = rsp_exp_ff;
   assign rsp_finished      = rsp_fin_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   `TSAF_ASSERT(a_accept_goes_busy, clock, reset, accept |=> busy)
   `TSAF_ASSERT(a_rsp_after_finish, clock, reset, rsp_valid_ff |-> $past(state_ff == StFinish))
   `TSAF_ASSERT(a_store_xor_drop, clock, reset, rsp_valid_ff |-> !(rsp_stored_ff && rsp_drop_ff))
   `TSAF_ASSERT(a_finish_is_empty, clock, reset,
      (rsp_valid_ff && rsp_fin_ff) |-> (rsp_live_ff == 6'd0))
   `TSAF_ASSERT_ALWAYS(a_idle_after_reset, clock, $past(reset) |-> (state_ff == StIdle))
endmodule

// ===== dv/trail_segment_aging_fifo_checker.sv =====
// Checker for the trail segment aging pool: predicts each tick result and compares it.
`timescale 1ns / 100ps

module trail_segment_aging_fifo_checker #(
   parameter int         SLOTS     = tsaf_pkg::SlotsDefault,
   parameter logic [2:0] FADE_ADDR = 3'd0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic [tsaf_pkg::TimeW-1:0] req_step_time,
   input  logic                       req_have_points,
   input  logic                       req_closing,
   input  logic                       rsp_valid,
   input  logic [5:0]                 rsp_live_segments,
   input  logic                       rsp_stored,
   input  logic [4:0]                 rsp_stored_slot,
   input  logic                       rsp_dropped_full,
   input  logic [5:0]                 rsp_expired_count,
   input  logic                       rsp_finished,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   input  logic [31:0]                prdata,
   input  logic                       pready,
   output int                         mismatch_count,
   output int                         results_seen
);
   import tsaf_pkg::*;

   typedef struct packed {
      logic [5:0] live_segments;
      logic       stored;
      logic [4:0] stored_slot;
      logic       dropped_full;
      logic [5:0] expired_count;
      logic       finished;
   } tick_result_type;

   logic [TimeW-1:0]  fade_time;
   logic [TimeW-1:0]  seg_left [SLOTS];
   logic              seg_live [SLOTS];
   logic [5:0]        seg_next [SLOTS];
   logic [5:0]        oldest;
   logic [5:0]        newest;
   logic [5:0]        live_count;
   logic [TimerW-1:0] emit_clock;
   tick_result_type   expected_ticks [$];
   tick_result_type   beat_seen;
   int                fail_total = 0;
   int                seen_total = 0;

   assign beat_seen = {rsp_live_segments, rsp_stored, rsp_stored_slot, rsp_dropped_full,
                       rsp_expired_count, rsp_finished};

   function automatic string describe_tick(input tick_result_type r);
      return $sformatf("live=%0d stored=%0b slot=%0d dropped=%0b expired=%0d finished=%0b",
                       r.live_segments, r.stored, r.stored_slot, r.dropped_full,
                       r.expired_count, r.finished);
   endfunction

   function automatic void log_failure(input string msg);
      fail_total++;
      if (fail_total <= 10) begin
         $display("[%0t] MISMATCH %s", $realtime, msg);
      end
   endfunction

   // Ages the chain, then stores the offered pair if the emit timer is due.
   function automatic tick_result_type predict_tick(input logic [TimeW-1:0] dt,
                                                    input logic offered,
                                                    input logic closing);
      tick_result_type r;
      int cur, prv, idx, nxt, left, walked, id;
      bit have_prv, at_tail;
      logic [TimerW:0] sum;
      r = '0;
      if (live_count > 0 && dt > 0) begin
         cur = oldest;
         prv = 0;
         have_prv = 1'b0;
         left = live_count;
         walked = 0;
         while (left > 0 && walked < SLOTS) begin
            idx = cur % SLOTS;
            nxt = int'(seg_next[idx]) % SLOTS;
            at_tail = (left == 1);
            walked++;
            left--;
            if (dt > seg_left[idx]) begin
               // Unlink where it stands, so a segment in mid-chain keeps the order.
               seg_live[idx] = 1'b0;
               seg_left[idx] = '0;
               live_count = live_count - 6'd1;
               r.expired_count = r.expired_count + 6'd1;
               if (have_prv) seg_next[prv] = 6'(nxt);
               else oldest = 6'(nxt);
               if (at_tail && have_prv) newest = 6'(prv);
            end else begin
               seg_left[idx] = seg_left[idx] - dt;
               prv = idx;
               have_prv = 1'b1;
            end
            cur = nxt;
         end
         if (live_count == 0) begin
            oldest = '0;
            newest = '0;
         end
      end

      sum = {1'b0, emit_clock} + (TimerW+1)'(dt);
      emit_clock = (sum > TimerMax) ? TimerMax : sum[TimerW-1:0];

      if (offered && longint'(emit_clock) * SLOTS >= OneSecond) begin
         emit_clock = '0;
         id = 0;
         while (id < SLOTS && seg_live[id]) id++;
         if (live_count >= SLOTS || id >= SLOTS) begin
            r.dropped_full = 1'b1;
         end else begin
            seg_live[id] = 1'b1;
            seg_left[id] = fade_time;
            seg_next[id] = '0;
            if (live_count == 0) oldest = 6'(id);
            else seg_next[int'(newest) % SLOTS] = 6'(id);
            newest = 6'(id);
            live_count = live_count + 6'd1;
            r.stored = 1'b1;
            r.stored_slot = 5'(id);
         end
      end

      // A dropped pair skips the finished check altogether.
      if (!r.dropped_full && closing && live_count == 0) r.finished = 1'b1;
      r.live_segments = live_count;
      return r;
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      if (reset) begin
         fade_time = FadeResetVal;
         for (int i = 0; i < SLOTS; i++) begin
            seg_left[i] = '0;
            seg_live[i] = 1'b0;
            seg_next[i] = '0;
         end
         oldest = '0;
         newest = '0;
         live_count = '0;
         emit_clock = '0;
         expected_ticks.delete();
      end else begin
         if (psel && penable && pready && paddr == FADE_ADDR) begin
            if (pwrite) begin
               fade_time = pwdata[TimeW-1:0];
            end else if (prdata !== 32'(fade_time)) begin
               log_failure($sformatf("fade_time read: expected %0h, got %0h",
                                     fade_time, prdata));
            end
         end
         if (rsp_valid) begin
            seen_total++;
            if (expected_ticks.size() == 0) begin
               log_failure($sformatf("result beat with none expected: %s",
                                     describe_tick(beat_seen)));
            end else begin
               want = expected_ticks.pop_front();
               if (beat_seen !== want) begin
                  log_failure($sformatf("result beat %0d: expected %s, got %s", seen_total,
                                        describe_tick(want), describe_tick(beat_seen)));
               end
            end
         end
         if (start && !busy) begin
            expected_ticks.push_back(predict_tick(req_step_time, req_have_points,
                                                  req_closing));
         end
      end
      mismatch_count <= fail_total;
      results_seen   <= seen_total;
   end

endmodule

// ===== dv/trail_segment_aging_fifo_tb.sv =====
// Testbench top for the trail segment aging pool: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module trail_segment_aging_fifo_tb;
   import tsaf_pkg::*;

   // The only register, fade_time, sits at byte address 0 of the configuration port.
   localparam logic [2:0] FadeTimeAddr = 3'd0;
   localparam int         Phases       = 6;
   localparam int         PhaseBeats   = 205;
   // Idle cycles run after the last result is back, before the verdict is given.
   localparam int         DrainCycles  = 40;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [TimeW-1:0]  req_step_time   = '0;
   logic              req_have_points = 1'b0;
   logic              req_closing     = 1'b0;
   logic [CoordW-1:0] req_first_x  = '0;
   logic [CoordW-1:0] req_first_y  = '0;
   logic [CoordW-1:0] req_first_z  = '0;
   logic [CoordW-1:0] req_second_x = '0;
   logic [CoordW-1:0] req_second_y = '0;
   logic [CoordW-1:0] req_second_z = '0;
   logic              rsp_valid;
   logic [5:0]        rsp_live_segments;
   logic              rsp_stored;
   logic [4:0]        rsp_stored_slot;
   logic              rsp_dropped_full;
   logic [5:0]        rsp_expired_count;
   logic              rsp_finished;
   logic              psel    = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite  = 1'b0;
   logic [2:0]        paddr   = '0;
   logic [31:0]       pwdata  = '0;
   logic [31:0]       prdata;
   logic              pready;

   int                mismatch_count;
   int                results_seen;
   int                ticks_sent = 0;
   // Our own note of the lifetime in force, used to aim step times at it.
   logic [TimeW-1:0]  fade_now = FadeResetVal;
   bit                gaps_on  = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   trail_segment_aging_fifo u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_step_time     (req_step_time),
      .req_have_points   (req_have_points),
      .req_closing       (req_closing),
      .req_first_x       (req_first_x),
      .req_first_y       (req_first_y),
      .req_first_z       (req_first_z),
      .req_second_x      (req_second_x),
      .req_second_y      (req_second_y),
      .req_second_z      (req_second_z),
      .rsp_valid         (rsp_valid),
      .rsp_live_segments (rsp_live_segments),
      .rsp_stored        (rsp_stored),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_dropped_full  (rsp_dropped_full),
      .rsp_expired_count (rsp_expired_count),
      .rsp_finished      (rsp_finished),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // The checker sits beside the block, watching both channels and the register port.
   trail_segment_aging_fifo_checker #(
      .FADE_ADDR (FadeTimeAddr)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_step_time     (req_step_time),
      .req_have_points   (req_have_points),
      .req_closing       (req_closing),
      .rsp_valid         (rsp_valid),
      .rsp_live_segments (rsp_live_segments),
      .rsp_stored        (rsp_stored),
      .rsp_stored_slot   (rsp_stored_slot),
      .rsp_dropped_full  (rsp_dropped_full),
      .rsp_expired_count (rsp_expired_count),
      .rsp_finished      (rsp_finished),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .mismatch_count    (mismatch_count),
      .results_seen      (results_seen)
   );

   // Every tick yields exactly one result beat, so the block is idle once the checker
   // has seen as many result beats as we have had tick beats accepted. The count from
   // the checker is registered, which only ever makes this wait a little longer.
   task automatic wait_for_results();
      while (results_seen != ticks_sent) @(posedge clock);
   endtask

   // Offers one tick beat and returns at the edge that accepts it. Before the beat there
   // may be a burst of idle cycles, either straight after the previous acceptance (so
   // the gap falls while the block is still sweeping) or after its result has come
   // back (so the gap falls while the block is idle). With no gap, start simply stays
   // high through busy, which also checks that nothing is taken while busy is high.
   task automatic send_tick(input logic [TimeW-1:0] dt, input logic offered,
                            input logic closing, input pts_type words);
      int mode;
      mode = gaps_on ? $urandom_range(0, 3) : 0;
      if (mode >= 2) begin
         start <= 1'b0;
         if (mode == 3) wait_for_results();
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start           <= 1'b1;
      req_step_time   <= dt;
      req_have_points <= offered;
      req_closing     <= closing;
      req_first_x     <= words.first_x;
      req_first_y     <= words.first_y;
      req_first_z     <= words.first_z;
      req_second_x    <= words.second_x;
      req_second_y    <= words.second_y;
      req_second_z    <= words.second_z;
      do @(posedge clock); while (busy);
      ticks_sent++;
   endtask

   // Writes fade_time with the block idle and reads it straight back; the checker
   // compares the read data. The upper bits of the write data are not part of the
   // register; the random phases feed them random values to show they are ignored.
   task automatic write_fade(input logic [31:0] value);
      start <= 1'b0;
      wait_for_results();
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      paddr   <= FadeTimeAddr;
      pwdata  <= value;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      fade_now = value[TimeW-1:0];
   endtask

   initial begin
      logic [TimeW-1:0] dt;
      logic [TimeW-1:0] fade_pick;
      int               pick;
      pts_type          words;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats, with the lifetime at its reset value of one second.
      // Closing on an empty pool, nothing due yet: the trail reports finished.
      send_tick(24'd0, 1'b1, 1'b1, '1);
      // One step short of the emit interval, then exactly on it: slot 0 is filled.
      send_tick(24'd2047, 1'b1, 1'b0, '1);
      send_tick(24'd1, 1'b1, 1'b0, '1);
      send_tick(24'd2048, 1'b1, 1'b0, '0);
      // The oldest segment is aged to exactly zero and survives, then goes on the next tick.
      send_tick(24'd63488, 1'b0, 1'b0, '0);
      send_tick(24'd1, 1'b0, 1'b0, '0);
      // The largest step clears the pool and leaves the new pair as the only segment.
      send_tick('1, 1'b1, 1'b1, {6{32'h5555_5555}});
      send_tick('1, 1'b0, 1'b1, '0);
      // Two more of the largest steps pin the emit timer at its ceiling.
      send_tick('1, 1'b0, 1'b0, '0);
      send_tick('1, 1'b0, 1'b0, '0);
      send_tick(24'd0, 1'b1, 1'b0, {6{32'hAAAA_AAAA}});

      // A short lifetime behind a long one: the newest segment expires away from the head.
      write_fade(32'd2048);
      send_tick(24'd2048, 1'b1, 1'b0, '1);
      send_tick(24'd2049, 1'b0, 1'b0, '0);
      send_tick(24'd2048, 1'b1, 1'b0, '1);
      send_tick(24'd4096, 1'b1, 1'b1, '0);
      // Zero lifetime: a segment survives a zero step only.
      write_fade(32'd0);
      send_tick(24'd2048, 1'b1, 1'b0, '1);
      send_tick(24'd1, 1'b0, 1'b1, '0);

      // Random phases, each under its own lifetime. The largest lifetime comes first so
      // the pool fills and drops pairs; the zero lifetime follows while those long-lived
      // segments remain, so short ones keep expiring behind them.
      for (int ph = 0; ph < Phases; ph++) begin
         case (ph)
            0:       fade_pick = '1;
            1:       fade_pick = '0;
            2:       fade_pick = TimeW'($urandom_range(2048, 40000));
            3:       fade_pick = FadeResetVal;
            4:       fade_pick = TimeW'($urandom);
            default: fade_pick = TimeW'($urandom_range(1, 4096));
         endcase
         write_fade({8'($urandom), fade_pick});
         gaps_on = (ph != Phases - 1);
         for (int n = 0; n < PhaseBeats; n++) begin
            // Mostly steps near the emit interval so pairs keep arriving, with some
            // zero steps, steps aimed at the lifetime and the odd step of any size.
            pick = $urandom_range(0, 99);
            if (pick < 55) dt = TimeW'($urandom_range(1500, 2600));
            else if (pick < 70) dt = '0;
            else if (pick < 85) dt = TimeW'($urandom_range(0, int'(fade_now) + 4));
            else if (pick < 95) dt = TimeW'($urandom_range(0, 65535));
            else dt = TimeW'($urandom);
            words = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            send_tick(dt, $urandom_range(0, 99) < 80, $urandom_range(0, 9) == 0, words);
         end
      end

      start <= 1'b0;
      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && results_seen == ticks_sent) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog: a time limit many times the slowest correct run.
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
